[rtl/weyl_mix_random_generator_defines.svh]
// Assertion macros used by the back-end RTL of the Weyl mix random generator
`ifndef WEYL_MIX_RANDOM_GENERATOR_DEFINES_SVH
`define WEYL_MIX_RANDOM_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication checked on every clock edge outside reset
`define WMRG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition that must hold on every clock edge outside reset
`define WMRG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`else
`define WMRG_ASSERT(label, prop, msg)
`define WMRG_ASSERT_ALWAYS(label, cond, msg)
`endif

`endif

[rtl/wmrg_pkg.sv]
// Shared types and constants of the Weyl mix random generator
package wmrg_pkg;

    localparam logic [31:0] WEYL_STEP    = 32'he120fc15;
    localparam logic [31:0] MIX_FIRST    = 32'h4a39b70d;
    localparam logic [31:0] MIX_SECOND   = 32'h12fad5c9;
    localparam logic [31:0] SEED_DEFAULT = 32'h12345678;

    // Function codes
    localparam logic [1:0] FUNC_RAW      = 2'd0;
    localparam logic [1:0] FUNC_UNSIGNED = 2'd1;
    localparam logic [1:0] FUNC_SIGNED   = 2'd2;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One classified job: result = lo + (need_div ? raw % span : raw)
    typedef struct packed {
        logic        need_div;
        logic [31:0] lo;
        logic [31:0] span;
        logic [31:0] raw;
    } t_job;

endpackage

[rtl/wmrg_front.sv]
// Front end: accepts beats, advances the Weyl counter, mixes and classifies
module wmrg_front
    import wmrg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_bound_a,
    input  logic [31:0] i_bound_b,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_value,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_ready
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MIX1 = 2'd1;
    localparam logic [1:0] F_MIX2 = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    // 32x32 multiply with the high half folded onto the low half
    function automatic logic [31:0] fold_mul(input logic [31:0] x, input logic [31:0] k);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, k};
        return p[63:32] ^ p[31:0];
    endfunction

    logic [1:0]  r_state, n_state;
    logic [31:0] r_counter;
    logic [31:0] r_word;
    logic [1:0]  r_func;
    logic [31:0] r_a, r_b;
    logic [31:0] r_lo, r_span;
    logic        r_ranged;

    logic        accept;
    logic        ranged;
    logic        swap;
    logic [31:0] lo, hi;

    assign accept = i_push && (r_state == F_IDLE);
    assign o_full = (r_state != F_IDLE);

    // Bound ordering; signed compare by flipping the sign bits
    always_comb begin
        ranged = (r_func == FUNC_UNSIGNED) || (r_func == FUNC_SIGNED);
        if (r_func == FUNC_SIGNED) begin
            swap = (r_a ^ 32'h8000_0000) > (r_b ^ 32'h8000_0000);
        end else begin
            swap = r_a > r_b;
        end
        lo = swap ? r_b : r_a;
        hi = swap ? r_a : r_b;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_MIX1;
            F_MIX1: n_state = F_MIX2;
            F_MIX2: n_state = F_PUSH;
            F_PUSH: if (i_job_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_counter <= SEED_DEFAULT;
        end else begin
            r_state <= n_state;
            if (i_seed_we) begin
                r_counter <= (i_seed_value == 32'd0) ? SEED_DEFAULT : i_seed_value;
            end else if (accept) begin
                r_counter <= r_counter + WEYL_STEP;
            end
        end
    end

    // Datapath: one multiply per cycle, registered in between
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= r_counter + WEYL_STEP;
            r_func <= i_func;
            r_a    <= i_bound_a;
            r_b    <= i_bound_b;
        end
        if (r_state == F_MIX1) begin
            r_word   <= fold_mul(r_word, MIX_FIRST);
            r_ranged <= ranged;
            r_lo     <= ranged ? lo : 32'd0;
            r_span   <= hi - lo + 32'd1;
        end
        if (r_state == F_MIX2) begin
            r_word <= fold_mul(r_word, MIX_SECOND);
        end
    end

    assign o_job_valid   = (r_state == F_PUSH);
    assign o_job.need_div = r_ranged && (r_span != 32'd0);
    assign o_job.lo       = r_lo;
    assign o_job.span     = r_span;
    assign o_job.raw      = r_word;

endmodule

[rtl/wmrg_queue.sv]
// Short job queue between the front end and the back end
module wmrg_queue
    import wmrg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_job i_wr_job,
    output logic o_rd_valid,
    input  logic i_rd,
    output t_job o_rd_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                wr, rd;

    assign o_wr_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = i_rd && o_rd_valid;
    assign o_rd_job = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (rd) r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (wr && !rd)      r_count <= r_count + 1'b1;
            else if (rd && !wr) r_count <= r_count - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr_ptr] <= i_wr_job;
    end

endmodule

[rtl/wmrg_back.sv]
// Back end: bit-serial modulo, final add and result register
`include "weyl_mix_random_generator_defines.svh"
module wmrg_back
    import wmrg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_take,
    input  t_job        i_job,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_random_word
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_span;
    logic [31:0] r_lo;
    logic [31:0] r_res;
    logic        r_out_valid;
    logic [31:0] r_out_word;

    logic        take;
    logic        slot_free;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] n_rem;

    assign take      = (r_state == B_IDLE) && i_job_valid;
    assign o_job_take = take;
    assign slot_free = !r_out_valid || i_pop;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[31]};
        diff  = trial - {1'b0, r_span};
        n_rem = diff[32] ? trial[31:0] : diff[31:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: if (take) r_state <= i_job.need_div ? B_DIV : B_DONE;
                B_DIV:  if (r_cnt == 5'd0) r_state <= B_DONE;
                B_DONE: if (slot_free) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
            if ((r_state == B_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_lo   <= i_job.lo;
            r_span <= i_job.span;
            r_dvd  <= i_job.raw;
            r_rem  <= 32'd0;
            r_cnt  <= 5'd31;
            r_res  <= i_job.lo + i_job.raw;
        end
        if (r_state == B_DIV) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) r_res <= r_lo + n_rem;
        end
        if ((r_state == B_DONE) && slot_free) begin
            r_out_word <= r_res;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_random_word = r_out_word;

    `WMRG_ASSERT_ALWAYS(a_rem_below_span, (r_state != B_DIV) || (r_rem < r_span), "remainder not below span")
    `WMRG_ASSERT_ALWAYS(a_span_nonzero, (r_state != B_DIV) || (r_span != 32'd0), "division by zero span")
    `WMRG_ASSERT(a_result_held, (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_word)), "waiting result lost")
    `WMRG_ASSERT(a_done_loads, ((r_state == B_DONE) && slot_free) |=> (r_out_valid && (r_state == B_IDLE)), "result not loaded")

endmodule

[rtl/weyl_mix_random_generator.sv]
// Top level of the Weyl mix random generator: front end, job queue, back end.
// A new beat is accepted only once the front end has mixed the last one (two multiplies) and
// passed it to the queue; in the ranged modes the modulo unit, one bit a cycle, then sets the pace.
// Reset is synchronous, active low: counter to 0x12345678, queue and result empty.
module weyl_mix_random_generator
    import wmrg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_bound_a,
    input  logic [31:0] i_bound_b,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_random_word,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_value
);

    logic fe_valid, fe_ready;
    t_job fe_job;
    logic q_valid, q_take;
    t_job q_job;

    wmrg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_func       (i_func),
        .i_bound_a    (i_bound_a),
        .i_bound_b    (i_bound_b),
        .i_seed_we    (i_seed_we),
        .i_seed_value (i_seed_value),
        .o_job_valid  (fe_valid),
        .o_job        (fe_job),
        .i_job_ready  (fe_ready)
    );

    wmrg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_job   (fe_job),
        .o_rd_valid (q_valid),
        .i_rd       (q_take),
        .o_rd_job   (q_job)
    );

    wmrg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .o_job_take    (q_take),
        .i_job         (q_job),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_random_word (o_random_word)
    );

endmodule

[test/tb_weyl_mix_random_generator.sv]
// Self-checking testbench for the Weyl mix random generator: predicted words vs DUT results
`timescale 1ns / 100ps

module tb_weyl_mix_random_generator;
    import wmrg_pkg::*;

    // Spare function code, behaves as the raw mode
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 300;

    // Expected-word predictor with its own counter copy
    class random_word_board;
        logic [31:0] weyl_count;
        logic [31:0] expected_words[$];
        int          mismatches;

        function new();
            weyl_count = SEED_DEFAULT;
            mismatches = 0;
        endfunction

        function void load_seed(logic [31:0] value);
            weyl_count = (value == 32'd0) ? SEED_DEFAULT : value;
        endfunction

        // 32x32 multiply, high half folded into low half
        function logic [31:0] fold_product(logic [31:0] x, logic [31:0] k);
            logic [63:0] p;
            p = {32'd0, x} * {32'd0, k};
            return p[63:32] ^ p[31:0];
        endfunction

        function void note_request(logic [1:0] func, logic [31:0] a, logic [31:0] b);
            logic [31:0] raw;
            logic [31:0] lo;
            logic [31:0] hi;
            logic [31:0] span;
            logic [31:0] word;
            logic        swap;
            weyl_count = weyl_count + WEYL_STEP;
            raw  = fold_product(fold_product(weyl_count, MIX_FIRST), MIX_SECOND);
            word = raw;
            if (func == FUNC_UNSIGNED || func == FUNC_SIGNED) begin
                swap = (func == FUNC_UNSIGNED) ? (a > b) : ($signed(a) > $signed(b));
                lo   = swap ? b : a;
                hi   = swap ? a : b;
                span = hi - lo + 32'd1;
                // full 2^32 span wraps to zero: no modulo
                word = (span == 32'd0) ? lo + raw : lo + raw % span;
            end
            expected_words.push_back(word);
        endfunction

        task report_mismatch(string msg);
            $display("%0t: ERROR %s", $time, msg);
            mismatches++;
        endtask

        task check_word(logic [31:0] got);
            logic [31:0] want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("random word %h with no request waiting", got));
            end else begin
                want = expected_words.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("random_word got %h, expected %h", got, want));
            end
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [1:0]  req_func    = FUNC_RAW;
    logic [31:0] req_bound_a = 32'd0;
    logic [31:0] req_bound_b = 32'd0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [31:0] random_word;
    logic        seed_we     = 1'b0;
    logic [31:0] seed_data   = 32'd0;

    random_word_board board = new();
    int hold_request = 0;

    weyl_mix_random_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_func        (req_func),
        .i_bound_a     (req_bound_a),
        .i_bound_b     (req_bound_b),
        .empty         (empty),
        .pop           (pop),
        .o_random_word (random_word),
        .i_seed_we     (seed_we),
        .i_seed_value  (seed_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: seed writes, accepted requests and accepted result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (seed_we)
                board.load_seed(seed_data);
            if (push && !full)
                board.note_request(req_func, req_bound_a, req_bound_b);
            if (pop && !empty)
                board.check_word(random_word);
        end
    end

    // Result side: stall phases of varying density, plus long hold-offs on request
    initial begin : result_sink
        int stall_left;
        int stall_max;
        int phase_left;
        stall_left = 0;
        stall_max  = 0;
        phase_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 200);
                case ($urandom_range(0, 2))
                    0: stall_max = 0;
                    1: stall_max = 2;
                    default: stall_max = 8;
                endcase
            end
            phase_left--;
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (stall_max != 0 && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, stall_max) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one request beat and hold it until accepted
    task automatic send_item(input logic [1:0] f, input logic [31:0] a, input logic [31:0] b);
        push        <= 1'b1;
        req_func    <= f;
        req_bound_a <= a;
        req_bound_b <= b;
        do @(posedge i_clk); while (full);
    endtask

    // Idle the request side, with junk on the fields
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            push        <= 1'b0;
            req_func    <= 2'($urandom);
            req_bound_a <= $urandom;
            req_bound_b <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every outstanding word
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (board.expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        seed_we   <= 1'b1;
        seed_data <= value;
        @(posedge i_clk);
        seed_we   <= 1'b0;
    endtask

    function automatic logic [1:0] pick_func();
        case ($urandom_range(0, 9))
            0, 1, 2: return FUNC_RAW;
            3, 4, 5: return FUNC_UNSIGNED;
            6, 7, 8: return FUNC_SIGNED;
            default: return FUNC_SPARE;
        endcase
    endfunction

    function automatic logic [31:0] corner_bound();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            4: return 32'hffff_fffe;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Bound pairs: random, narrow spans, equal, corner values; either order
    function automatic void pick_bounds(output logic [31:0] a, output logic [31:0] b);
        logic [31:0] base;
        logic [31:0] t;
        base = $urandom;
        case ($urandom_range(0, 5))
            0, 1: begin
                a = $urandom;
                b = $urandom;
            end
            2: begin
                a = base;
                b = base + $urandom_range(0, 15);
            end
            3: begin
                a = base;
                b = base;
            end
            4: begin
                a = corner_bound();
                b = base;
            end
            default: begin
                a = corner_bound();
                b = corner_bound();
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            t = a;
            a = b;
            b = t;
        end
    endfunction

    // Random requests in bursts with random gaps
    task automatic send_random_items(input int count);
        int          burst_left;
        logic [1:0]  f;
        logic [31:0] a;
        logic [31:0] b;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            f = pick_func();
            pick_bounds(a, b);
            send_item(f, a, b);
        end
    endtask

    // Run limit
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        logic [31:0] seeds[6];
        seeds[0] = 32'h0000_0000;
        seeds[1] = 32'hffff_ffff;
        seeds[2] = 32'h0000_0001;
        seeds[3] = $urandom;
        seeds[4] = 32'h8000_0000;
        seeds[5] = SEED_DEFAULT;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // raw and spare modes ignore the bounds
        send_item(FUNC_RAW,   32'h0000_0000, 32'hffff_ffff);
        send_item(FUNC_RAW,   32'hffff_ffff, 32'h0000_0000);
        send_item(FUNC_SPARE, 32'h1234_5678, 32'h0000_0001);
        send_item(FUNC_SPARE, 32'hffff_ffff, 32'hffff_ffff);
        // unsigned: full span both orders, single value, swap, extremes
        send_item(FUNC_UNSIGNED, 32'h0000_0000, 32'hffff_ffff);
        send_item(FUNC_UNSIGNED, 32'hffff_ffff, 32'h0000_0000);
        send_item(FUNC_UNSIGNED, 32'h0000_0005, 32'h0000_0005);
        send_item(FUNC_UNSIGNED, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_UNSIGNED, 32'hffff_ffff, 32'hffff_ffff);
        send_item(FUNC_UNSIGNED, 32'h0000_000a, 32'h0000_0003);
        send_item(FUNC_UNSIGNED, 32'h0000_0003, 32'h0000_000a);
        send_item(FUNC_UNSIGNED, 32'h0000_0000, 32'h0000_0001);
        send_item(FUNC_UNSIGNED, 32'hffff_fffe, 32'hffff_ffff);
        send_item(FUNC_UNSIGNED, 32'h0000_0000, 32'h7fff_ffff);
        send_item(FUNC_UNSIGNED, 32'h0000_0001, 32'hffff_ffff);
        // signed: full span both orders, sign-dependent ordering, extremes
        send_item(FUNC_SIGNED, 32'h8000_0000, 32'h7fff_ffff);
        send_item(FUNC_SIGNED, 32'h7fff_ffff, 32'h8000_0000);
        send_item(FUNC_SIGNED, 32'hffff_ffff, 32'h0000_0001);
        send_item(FUNC_SIGNED, 32'h0000_0001, 32'hffff_ffff);
        send_item(FUNC_SIGNED, 32'h8000_0000, 32'h8000_0000);
        send_item(FUNC_SIGNED, 32'hffff_fffb, 32'hffff_fffb);
        send_item(FUNC_SIGNED, 32'h8000_0000, 32'h8000_0001);
        send_item(FUNC_SIGNED, 32'h7fff_fffe, 32'h7fff_ffff);
        send_item(FUNC_SIGNED, 32'h0000_0000, 32'h0000_0000);
        drain_results();

        // one phase per seed; two phases start with a long result hold-off
        for (int k = 0; k < 6; k++) begin
            write_seed(seeds[k]);
            if (k == 1 || k == 4)
                hold_request = LONG_HOLD;
            send_random_items(PHASE_ITEMS);
            drain_results();
        end

        repeat (48) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
